// File: rtl/core/sovb_pkg.sv
`timescale 1ns / 1ps

package sovb_pkg;

   // Default number format: signed Q16.16 in 32-bit words.
   localparam int FRAC_BITS_DEF  = 16;
   localparam int WORD_WIDTH_DEF = 32;

   // Offset components are scaled down to this many bits before squaring.
   localparam int NORM_BITS = 30;

   // Time scales at or above this many seconds disable the spring.
   localparam int TS_LIMIT_SEC = 600;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_Z      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REST_DISTANCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_SCALE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_SET    = 3'd5;

endpackage

// File: rtl/core/spring_offset_velocity_blend_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req       in         start high, busy low    req_pos_*, req_vel_*, req_time_step
// rsp       out        rsp_valid strobe        rsp_new_vel_*, rsp_applied
// csr       in         csr_valid and csr_ready csr_index, csr_data
//
// One item enters every cycle; busy and csr_ready are constant.
// Depth follows the word format (Q16.16 by default) and is set by the square root
// (one root bit per stage) and the dividers (one quotient bit per stage).
// Synchronous reset clears valid bits and settings, except time scale (all ones).
// The receiver cannot stall, so the pipeline never holds.
module spring_offset_velocity_blend_core #(
   parameter int FRAC_BITS  = sovb_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = sovb_pkg::WORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [WORD_WIDTH-1:0]        req_pos_x,
   input  logic signed [WORD_WIDTH-1:0]        req_pos_y,
   input  logic signed [WORD_WIDTH-1:0]        req_pos_z,
   input  logic signed [WORD_WIDTH-1:0]        req_vel_x,
   input  logic signed [WORD_WIDTH-1:0]        req_vel_y,
   input  logic signed [WORD_WIDTH-1:0]        req_vel_z,
   input  logic [WORD_WIDTH-1:0]               req_time_step,
   output logic                                rsp_valid,
   output logic signed [WORD_WIDTH-1:0]        rsp_new_vel_x,
   output logic signed [WORD_WIDTH-1:0]        rsp_new_vel_y,
   output logic signed [WORD_WIDTH-1:0]        rsp_new_vel_z,
   output logic                                rsp_applied,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sovb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [WORD_WIDTH-1:0]               csr_data
);

   localparam int WW  = WORD_WIDTH;
   localparam int FB  = FRAC_BITS;
   localparam int NB  = sovb_pkg::NORM_BITS;
   localparam int RW  = NB + 1;
   localparam int SW  = $clog2(WW + 2);
   localparam int DW  = (WW + 2 > RW) ? WW + 2 : RW;
   localparam int NW  = DW + FB;
   localparam int UW  = FB + 2;
   localparam int AW  = WW + FB + 8;
   localparam int PL  = 8;
   localparam int LAT = 5 + RW + 1 + NW + PL;

   localparam logic [WW+10:0] TS_LIMIT_Q = (WW + 11)'(sovb_pkg::TS_LIMIT_SEC) << FB;
   localparam logic [NW-1:0] TS_HALF = NW'(1) << (WW - 1);
   localparam logic [NW-1:0] TS_MAXU = TS_HALF - NW'(1);
   localparam logic [WW-1:0] SMAX = {1'b0, {(WW-1){1'b1}}};
   localparam logic [WW-1:0] SMIN = {1'b1, {(WW-1){1'b0}}};
   localparam logic signed [AW-1:0] SMAX_A = {{(AW-WW+1){1'b0}}, {(WW-1){1'b1}}};
   localparam logic signed [AW-1:0] SMIN_A = {{(AW-WW+1){1'b1}}, {(WW-1){1'b0}}};
   localparam logic signed [AW-1:0] TZ_BIAS = (AW'(1) << FB) - AW'(1);
   localparam logic [FB:0] B_ONE = {1'b1, {FB{1'b0}}};

   typedef struct packed {
      logic                 vld;
      logic                 ok;
      logic signed [WW-1:0] v0;
      logic signed [WW-1:0] v1;
      logic signed [WW-1:0] v2;
      logic [WW-1:0]        dt;
      logic                 n0;
      logic                 n1;
      logic                 n2;
      logic [WW:0]          m0;
      logic [WW:0]          m1;
      logic [WW:0]          m2;
      logic [SW-1:0]        sh;
      logic [NB-1:0]        q0;
      logic [NB-1:0]        q1;
      logic [NB-1:0]        q2;
      logic [2*NB-1:0]      s0;
      logic [2*NB-1:0]      s1;
      logic [2*NB-1:0]      s2;
      logic [2*RW-1:0]      sum;
   } fst_type;

   typedef struct packed {
      logic                 vld;
      logic                 ok;
      logic signed [WW-1:0] v0;
      logic signed [WW-1:0] v1;
      logic signed [WW-1:0] v2;
      logic [WW-1:0]        dt;
      logic                 n0;
      logic                 n1;
      logic                 n2;
      logic [NB-1:0]        q0;
      logic [NB-1:0]        q1;
      logic [NB-1:0]        q2;
      logic [RW-1:0]        r;
      logic                 dneg;
      logic [DW-1:0]        dmag;
   } mst_type;

   typedef struct packed {
      logic                 vld;
      logic                 ok;
      logic signed [WW-1:0] v0;
      logic signed [WW-1:0] v1;
      logic signed [WW-1:0] v2;
      logic signed [UW-1:0] u0;
      logic signed [UW-1:0] u1;
      logic signed [UW-1:0] u2;
      logic signed [WW-1:0] ts;
      logic [FB:0]          b;
      logic signed [AW-1:0] a0;
      logic signed [AW-1:0] a1;
      logic signed [AW-1:0] a2;
   } pst_type;

   // Signed divide by 2^FB, truncating toward zero.
   function automatic logic signed [AW-1:0] tz_shift(input logic signed [AW-1:0] x);
      logic signed [AW-1:0] t;
      t = $signed(x + (x[AW-1] ? TZ_BIAS : $signed(AW'(0))));
      return t >>> FB;
   endfunction

   function automatic logic [WW-1:0] sat_word(input logic signed [AW-1:0] x);
      logic [WW-1:0] y;
      if (x > SMAX_A) begin
         y = SMAX;
      end else if (x < SMIN_A) begin
         y = SMIN;
      end else begin
         y = x[WW-1:0];
      end
      return y;
   endfunction

   logic signed [WW-1:0] anchor_x_ff;
   logic signed [WW-1:0] anchor_y_ff;
   logic signed [WW-1:0] anchor_z_ff;
   logic [WW-2:0]        rest_ff;
   logic [WW-1:0]        tscale_ff;
   logic                 tset_ff;
   logic                 ok_cfg;

   fst_type fst_ff   [5];
   fst_type fst_in   [5];
   fst_type sq_dl_ff [RW];
   mst_type mst_ff;
   mst_type mst_in;
   mst_type dv_dl_ff [NW];
   pst_type pst_ff   [PL];
   pst_type pst_in   [PL];

   logic [RW-1:0] root;
   logic [NW-1:0] quo_u0, quo_u1, quo_u2, quo_ts, quo_b;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         anchor_z_ff <= '0;
         rest_ff     <= '0;
         tscale_ff   <= '1;
         tset_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sovb_pkg::REG_ANCHOR_X:      anchor_x_ff <= csr_data;
            sovb_pkg::REG_ANCHOR_Y:      anchor_y_ff <= csr_data;
            sovb_pkg::REG_ANCHOR_Z:      anchor_z_ff <= csr_data;
            sovb_pkg::REG_REST_DISTANCE: rest_ff     <= csr_data[WW-2:0];
            sovb_pkg::REG_TIME_SCALE:    tscale_ff   <= csr_data;
            sovb_pkg::REG_TARGET_SET:    tset_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign ok_cfg = tset_ff && (tscale_ff != '0) && ({11'b0, tscale_ff} < TS_LIMIT_Q);

   // Front stages: offset, scale shift, normalized components, squares, sum.
   always_comb begin
      logic signed [WW:0] d0, d1, d2;
      logic [WW:0]        orm;
      logic [SW-1:0]      sh;
      d0 = {req_pos_x[WW-1], req_pos_x} - {anchor_x_ff[WW-1], anchor_x_ff};
      d1 = {req_pos_y[WW-1], req_pos_y} - {anchor_y_ff[WW-1], anchor_y_ff};
      d2 = {req_pos_z[WW-1], req_pos_z} - {anchor_z_ff[WW-1], anchor_z_ff};
      fst_in[0]     = '0;
      fst_in[0].vld = start && !busy;
      fst_in[0].ok  = ok_cfg;
      fst_in[0].v0  = req_vel_x;
      fst_in[0].v1  = req_vel_y;
      fst_in[0].v2  = req_vel_z;
      fst_in[0].dt  = req_time_step;
      fst_in[0].n0  = d0[WW];
      fst_in[0].n1  = d1[WW];
      fst_in[0].n2  = d2[WW];
      fst_in[0].m0  = d0[WW] ? (WW+1)'(-d0) : d0;
      fst_in[0].m1  = d1[WW] ? (WW+1)'(-d1) : d1;
      fst_in[0].m2  = d2[WW] ? (WW+1)'(-d2) : d2;

      // The highest set bit of the largest magnitude sets the shift.
      fst_in[1] = fst_ff[0];
      orm = fst_ff[0].m0 | fst_ff[0].m1 | fst_ff[0].m2;
      sh  = '0;
      for (int i = NB; i <= WW; i++) begin
         if (orm[i]) begin
            sh = SW'(i + 1 - NB);
         end
      end
      fst_in[1].sh = sh;

      fst_in[2]    = fst_ff[1];
      fst_in[2].q0 = NB'(fst_ff[1].m0 >> fst_ff[1].sh);
      fst_in[2].q1 = NB'(fst_ff[1].m1 >> fst_ff[1].sh);
      fst_in[2].q2 = NB'(fst_ff[1].m2 >> fst_ff[1].sh);

      fst_in[3]    = fst_ff[2];
      fst_in[3].s0 = fst_ff[2].q0 * fst_ff[2].q0;
      fst_in[3].s1 = fst_ff[2].q1 * fst_ff[2].q1;
      fst_in[3].s2 = fst_ff[2].q2 * fst_ff[2].q2;

      fst_in[4]     = fst_ff[3];
      fst_in[4].sum = (2*RW)'(fst_ff[3].s0) + (2*RW)'(fst_ff[3].s1)
                    + (2*RW)'(fst_ff[3].s2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) begin
            fst_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < 5; k++) begin
            fst_ff[k] <= fst_in[k];
         end
      end
   end

   sovb_sqrt #(.RW(RW)) u_sqrt (
      .clock (clock),
      .rad   (fst_ff[4].sum),
      .root  (root)
   );

   // Item fields travel alongside the square root stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RW; k++) begin
            sq_dl_ff[k] <= '0;
         end
      end else begin
         sq_dl_ff[0] <= fst_ff[4];
         for (int k = 1; k < RW; k++) begin
            sq_dl_ff[k] <= sq_dl_ff[k-1];
         end
      end
   end

   // Distance, tiny distance check and signed offset from the rest distance.
   always_comb begin
      logic [DW-1:0]        span;
      logic signed [DW:0]   diff;
      span = DW'(root) << sq_dl_ff[RW-1].sh;
      diff = {1'b0, span} - (DW+1)'(rest_ff);
      mst_in.vld  = sq_dl_ff[RW-1].vld;
      mst_in.ok   = sq_dl_ff[RW-1].ok && (span > DW'(1));
      mst_in.v0   = sq_dl_ff[RW-1].v0;
      mst_in.v1   = sq_dl_ff[RW-1].v1;
      mst_in.v2   = sq_dl_ff[RW-1].v2;
      mst_in.dt   = sq_dl_ff[RW-1].dt;
      mst_in.n0   = sq_dl_ff[RW-1].n0;
      mst_in.n1   = sq_dl_ff[RW-1].n1;
      mst_in.n2   = sq_dl_ff[RW-1].n2;
      mst_in.q0   = sq_dl_ff[RW-1].q0;
      mst_in.q1   = sq_dl_ff[RW-1].q1;
      mst_in.q2   = sq_dl_ff[RW-1].q2;
      mst_in.r    = root;
      mst_in.dneg = diff[DW];
      mst_in.dmag = diff[DW] ? DW'(-diff) : diff[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mst_ff <= '0;
      end else begin
         mst_ff <= mst_in;
      end
   end

   // Unit axis, target speed and blend factor divisions.
   sovb_div #(.NW(NW), .DW(DW)) u_div_u0 (
      .clock (clock),
      .num   (NW'(mst_ff.q0) << FB),
      .den   (DW'(mst_ff.r)),
      .quo   (quo_u0)
   );

   sovb_div #(.NW(NW), .DW(DW)) u_div_u1 (
      .clock (clock),
      .num   (NW'(mst_ff.q1) << FB),
      .den   (DW'(mst_ff.r)),
      .quo   (quo_u1)
   );

   sovb_div #(.NW(NW), .DW(DW)) u_div_u2 (
      .clock (clock),
      .num   (NW'(mst_ff.q2) << FB),
      .den   (DW'(mst_ff.r)),
      .quo   (quo_u2)
   );

   sovb_div #(.NW(NW), .DW(DW)) u_div_ts (
      .clock (clock),
      .num   (NW'(mst_ff.dmag) << FB),
      .den   (DW'(tscale_ff)),
      .quo   (quo_ts)
   );

   sovb_div #(.NW(NW), .DW(DW)) u_div_b (
      .clock (clock),
      .num   (NW'(mst_ff.dt) << FB),
      .den   (DW'(tscale_ff)),
      .quo   (quo_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NW; k++) begin
            dv_dl_ff[k] <= '0;
         end
      end else begin
         dv_dl_ff[0] <= mst_ff;
         for (int k = 1; k < NW; k++) begin
            dv_dl_ff[k] <= dv_dl_ff[k-1];
         end
      end
   end

   // Back stages: signs and clamps, parallel speed, blend, velocity update.
   always_comb begin
      logic [UW-1:0]                uq0, uq1, uq2;
      logic signed [WW+UW-1:0]      pr0, pr1, pr2;
      logic signed [WW+4:0]         e5;
      logic signed [FB+1:0]         bs;
      logic signed [WW+FB+6:0]      pb;
      logic signed [WW+FB+6:0]      pk0, pk1, pk2;
      logic signed [AW-1:0]         z0, z1, z2;

      // Sign the axis, negate and saturate the target speed, clamp the blend factor.
      uq0 = UW'(quo_u0[FB:0]);
      uq1 = UW'(quo_u1[FB:0]);
      uq2 = UW'(quo_u2[FB:0]);
      pst_in[0]     = '0;
      pst_in[0].vld = dv_dl_ff[NW-1].vld;
      pst_in[0].ok  = dv_dl_ff[NW-1].ok;
      pst_in[0].v0  = dv_dl_ff[NW-1].v0;
      pst_in[0].v1  = dv_dl_ff[NW-1].v1;
      pst_in[0].v2  = dv_dl_ff[NW-1].v2;
      pst_in[0].u0  = dv_dl_ff[NW-1].n0 ? UW'(-uq0) : uq0;
      pst_in[0].u1  = dv_dl_ff[NW-1].n1 ? UW'(-uq1) : uq1;
      pst_in[0].u2  = dv_dl_ff[NW-1].n2 ? UW'(-uq2) : uq2;
      if (dv_dl_ff[NW-1].dneg) begin
         pst_in[0].ts = (quo_ts > TS_MAXU) ? SMAX : quo_ts[WW-1:0];
      end else begin
         pst_in[0].ts = (quo_ts >= TS_HALF) ? SMIN : WW'(-quo_ts);
      end
      pst_in[0].b = (quo_b > NW'(B_ONE)) ? B_ONE : quo_b[FB:0];

      // Velocity times axis, per component.
      pst_in[1] = pst_ff[0];
      pr0 = pst_ff[0].v0 * pst_ff[0].u0;
      pr1 = pst_ff[0].v1 * pst_ff[0].u1;
      pr2 = pst_ff[0].v2 * pst_ff[0].u2;
      pst_in[1].a0 = AW'(pr0);
      pst_in[1].a1 = AW'(pr1);
      pst_in[1].a2 = AW'(pr2);

      // Parallel speed.
      pst_in[2]    = pst_ff[1];
      pst_in[2].a0 = tz_shift(pst_ff[1].a0 + pst_ff[1].a1 + pst_ff[1].a2);

      // Speed error toward the target.
      pst_in[3]    = pst_ff[2];
      pst_in[3].a0 = AW'(pst_ff[2].ts) - pst_ff[2].a0;

      // Blend factor times speed error.
      pst_in[4] = pst_ff[3];
      e5 = pst_ff[3].a0[WW+4:0];
      bs = {1'b0, pst_ff[3].b};
      pb = bs * e5;
      pst_in[4].a0 = AW'(pb);

      pst_in[5]    = pst_ff[4];
      pst_in[5].a0 = tz_shift(pst_ff[4].a0);

      // Correction along the axis, per component.
      pst_in[6] = pst_ff[5];
      e5  = pst_ff[5].a0[WW+4:0];
      pk0 = e5 * pst_ff[5].u0;
      pk1 = e5 * pst_ff[5].u1;
      pk2 = e5 * pst_ff[5].u2;
      pst_in[6].a0 = AW'(pk0);
      pst_in[6].a1 = AW'(pk1);
      pst_in[6].a2 = AW'(pk2);

      // New velocity, saturated; pass-through when no update applies.
      pst_in[7] = pst_ff[6];
      z0 = AW'(pst_ff[6].v0) + tz_shift(pst_ff[6].a0);
      z1 = AW'(pst_ff[6].v1) + tz_shift(pst_ff[6].a1);
      z2 = AW'(pst_ff[6].v2) + tz_shift(pst_ff[6].a2);
      if (pst_ff[6].ok) begin
         pst_in[7].v0 = sat_word(z0);
         pst_in[7].v1 = sat_word(z1);
         pst_in[7].v2 = sat_word(z2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PL; k++) begin
            pst_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < PL; k++) begin
            pst_ff[k] <= pst_in[k];
         end
      end
   end

   assign rsp_valid     = pst_ff[PL-1].vld;
   assign rsp_new_vel_x = pst_ff[PL-1].v0;
   assign rsp_new_vel_y = pst_ff[PL-1].v1;
   assign rsp_new_vel_z = pst_ff[PL-1].v2;
   assign rsp_applied   = pst_ff[PL-1].ok;

   // Every result comes from an item accepted at the pipeline input.
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching item");

   // A skipped update returns the velocity the item carried.
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_applied |->
         (rsp_new_vel_x == $past(req_vel_x, LAT)) &&
         (rsp_new_vel_y == $past(req_vel_y, LAT)) &&
         (rsp_new_vel_z == $past(req_vel_z, LAT)))
      else $error("pass-through velocity altered");

   // An applied update needs a set target and a nonzero time scale.
   a_applied_cfg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_applied |-> tset_ff && (tscale_ff != '0))
      else $error("update applied with spring disabled");

endmodule

// File: rtl/core/sovb_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage.
module sovb_sqrt #(
   parameter int RW = 31
) (
   input  logic              clock,
   input  logic [2*RW-1:0]   rad,
   output logic [RW-1:0]     root
);

   logic [RW:0]     rem_ff  [RW];
   logic [RW:0]     rem_in  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [RW-1:0]   root_in [RW];
   logic [2*RW-1:0] rad_ff  [RW];
   logic [2*RW-1:0] rad_in  [RW];

   // Each stage brings down two radicand bits and tries the next root bit.
   always_comb begin
      logic [RW:0]     rs;
      logic [RW-1:0]   os;
      logic [2*RW-1:0] ds;
      logic [RW+2:0]   cur;
      logic [RW+2:0]   trial;
      logic            ge;
      for (int j = 0; j < RW; j++) begin
         if (j == 0) begin
            rs = '0;
            os = '0;
            ds = rad;
         end else begin
            rs = rem_ff[j-1];
            os = root_ff[j-1];
            ds = rad_ff[j-1];
         end
         cur   = {rs, ds[2*RW-1 -: 2]};
         trial = {1'b0, os, 2'b01};
         ge    = (cur >= trial);
         rem_in[j]  = ge ? (RW+1)'(cur - trial) : cur[RW:0];
         root_in[j] = {os[RW-2:0], ge};
         rad_in[j]  = ds << 2;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < RW; j++) begin
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
         rad_ff[j]  <= rad_in[j];
      end
   end

   assign root = root_ff[RW-1];

endmodule

// File: rtl/core/sovb_div.sv
`timescale 1ns / 1ps

// Pipelined unsigned restoring divider, one quotient bit per stage.
module sovb_div #(
   parameter int NW = 50,
   parameter int DW = 34
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);

   logic [DW-1:0] rem_ff [NW];
   logic [DW-1:0] rem_in [NW];
   logic [NW-1:0] num_ff [NW];
   logic [NW-1:0] num_in [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [NW-1:0] quo_in [NW];
   logic [DW-1:0] den_ff [NW];
   logic [DW-1:0] den_in [NW];

   // Shift in one numerator bit and subtract the divisor where it fits.
   always_comb begin
      logic [DW-1:0] rs;
      logic [NW-1:0] ns;
      logic [NW-1:0] qs;
      logic [DW-1:0] ds;
      logic [DW:0]   trial;
      logic          ge;
      for (int j = 0; j < NW; j++) begin
         if (j == 0) begin
            rs = '0;
            ns = num;
            qs = '0;
            ds = den;
         end else begin
            rs = rem_ff[j-1];
            ns = num_ff[j-1];
            qs = quo_ff[j-1];
            ds = den_ff[j-1];
         end
         trial = {rs, ns[NW-1]};
         ge    = (trial >= {1'b0, ds});
         rem_in[j] = ge ? DW'(trial - {1'b0, ds}) : trial[DW-1:0];
         num_in[j] = ns << 1;
         quo_in[j] = {qs[NW-2:0], ge};
         den_in[j] = ds;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NW; j++) begin
         rem_ff[j] <= rem_in[j];
         num_ff[j] <= num_in[j];
         quo_ff[j] <= quo_in[j];
         den_ff[j] <= den_in[j];
      end
   end

   assign quo = quo_ff[NW-1];

endmodule

// File: verif/sovb_checker.sv
`timescale 1ns / 1ps

// Watches the request, response and register channels, predicts the new
// velocity of every accepted item and compares it with what comes out.
module sovb_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic signed [31:0]             req_pos_x,
   input  logic signed [31:0]             req_pos_y,
   input  logic signed [31:0]             req_pos_z,
   input  logic signed [31:0]             req_vel_x,
   input  logic signed [31:0]             req_vel_y,
   input  logic signed [31:0]             req_vel_z,
   input  logic [31:0]                    req_time_step,
   input  logic                           rsp_valid,
   input  logic signed [31:0]             rsp_new_vel_x,
   input  logic signed [31:0]             rsp_new_vel_y,
   input  logic signed [31:0]             rsp_new_vel_z,
   input  logic                           rsp_applied,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [sovb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   output int                             mismatches,
   output int                             pending,
   output int                             applied_count
);

   localparam int     FRAC    = sovb_pkg::FRAC_BITS_DEF;
   localparam longint ONE_Q   = longint'(1) << FRAC;
   localparam longint WORD_MAX = 64'sh7FFF_FFFF;
   localparam longint WORD_MIN = -64'sh8000_0000;
   localparam longint unsigned SCALE_LIMIT = longint'(sovb_pkg::TS_LIMIT_SEC) << FRAC;

   typedef struct packed {
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic        applied;
   } blend_out_type;

   // Shadow copy of the block's registers.
   logic signed [31:0] anchor_q [3];
   logic [30:0]        rest_q;
   logic [31:0]        scale_q;
   logic               armed_q;

   blend_out_type expected_vel_q[$];

   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // One spring step on the current register settings.
   function automatic blend_out_type blend_step(
      input logic signed [31:0] px, py, pz, vx, vy, vz,
      input logic [31:0] dt
   );
      longint d[3], e[3], u[3], vel[3], res[3];
      longint unsigned m, sum, q, r, span, bitv;
      longint diff, ts, p, b, k;
      int s;
      bit ok;
      blend_out_type o;
      d[0] = longint'(px) - longint'(anchor_q[0]);
      d[1] = longint'(py) - longint'(anchor_q[1]);
      d[2] = longint'(pz) - longint'(anchor_q[2]);
      vel[0] = longint'(vx);
      vel[1] = longint'(vy);
      vel[2] = longint'(vz);
      for (int i = 0; i < 3; i++) res[i] = vel[i];
      ok = armed_q && scale_q != 0 && longint'(scale_q) < SCALE_LIMIT;
      m = 0;
      sum = 0;
      r = 0;
      if (ok) begin
         for (int i = 0; i < 3; i++) begin
            q = (d[i] < 0) ? -d[i] : d[i];
            if (q > m) m = q;
         end
         s = $clog2(m + 1) - sovb_pkg::NORM_BITS;
         if (s < 0) s = 0;
         for (int i = 0; i < 3; i++) begin
            q = ((d[i] < 0) ? -d[i] : d[i]) >> s;
            e[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
            sum += q * q;
         end
         // Integer square root, two bits per pass.
         bitv = 64'h4000_0000_0000_0000;
         while (bitv > sum) bitv >>= 2;
         while (bitv != 0) begin
            if (sum >= r + bitv) begin
               sum -= r + bitv;
               r = (r >> 1) + bitv;
            end else begin
               r >>= 1;
            end
            bitv >>= 2;
         end
         span = r << s;
         ok = span > 1;
      end
      if (ok) begin
         for (int i = 0; i < 3; i++) u[i] = (e[i] * ONE_Q) / longint'(r);
         diff = longint'(span) - longint'(rest_q);
         ts = clamp_word(-((diff * ONE_Q) / longint'(scale_q)));
         p = (vel[0] * u[0] + vel[1] * u[1] + vel[2] * u[2]) / ONE_Q;
         b = longint'((longint'(dt) << FRAC) / longint'(scale_q));
         if (b > ONE_Q) b = ONE_Q;
         k = (b * (ts - p)) / ONE_Q;
         for (int i = 0; i < 3; i++) res[i] = clamp_word(vel[i] + (k * u[i]) / ONE_Q);
      end
      o.vx = res[0][31:0];
      o.vy = res[1][31:0];
      o.vz = res[2][31:0];
      o.applied = ok;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
   endtask

   assign pending = expected_vel_q.size();

   always @(posedge clock) begin
      blend_out_type want;
      if (reset) begin
         mismatches = 0;
         applied_count = 0;
         anchor_q[0] <= '0;
         anchor_q[1] <= '0;
         anchor_q[2] <= '0;
         rest_q <= '0;
         scale_q <= '1;
         armed_q <= 1'b0;
         expected_vel_q.delete();
      end else begin
         // Predict every accepted item from the settings in force.
         if (start && !busy)
            expected_vel_q.push_back(blend_step(req_pos_x, req_pos_y, req_pos_z,
                                                req_vel_x, req_vel_y, req_vel_z,
                                                req_time_step));
         // Compare each strobed result with the oldest prediction.
         if (rsp_valid) begin
            if (expected_vel_q.size() == 0) begin
               report_mismatch("rsp_valid with no item outstanding", 32'(0), 32'(1));
            end else begin
               want = expected_vel_q.pop_front();
               if (want.applied) applied_count++;
               if (rsp_new_vel_x !== want.vx) report_mismatch("new_vel_x", want.vx, rsp_new_vel_x);
               if (rsp_new_vel_y !== want.vy) report_mismatch("new_vel_y", want.vy, rsp_new_vel_y);
               if (rsp_new_vel_z !== want.vz) report_mismatch("new_vel_z", want.vz, rsp_new_vel_z);
               if (rsp_applied !== want.applied)
                  report_mismatch("applied", 32'(want.applied), 32'(rsp_applied));
            end
         end
         // Register writes; unmapped indexes are dropped.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sovb_pkg::REG_ANCHOR_X:      anchor_q[0] <= csr_data;
               sovb_pkg::REG_ANCHOR_Y:      anchor_q[1] <= csr_data;
               sovb_pkg::REG_ANCHOR_Z:      anchor_q[2] <= csr_data;
               sovb_pkg::REG_REST_DISTANCE: rest_q <= csr_data[30:0];
               sovb_pkg::REG_TIME_SCALE:    scale_q <= csr_data;
               sovb_pkg::REG_TARGET_SET:    armed_q <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: verif/tb_spring_offset_velocity_blend_core.sv
`timescale 1ns / 1ps

module tb_spring_offset_velocity_blend_core;

   localparam int LATENCY = 120;
   localparam logic [sovb_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam logic [31:0] SCALE_ONE   = 32'h0001_0000;
   localparam logic [31:0] SCALE_LIMIT =
      32'(sovb_pkg::TS_LIMIT_SEC) << sovb_pkg::FRAC_BITS_DEF;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 88;

   logic clock, reset, start, busy;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [31:0] req_vel_x, req_vel_y, req_vel_z;
   logic [31:0] req_time_step;
   logic rsp_valid, rsp_applied;
   logic signed [31:0] rsp_new_vel_x, rsp_new_vel_y, rsp_new_vel_z;
   logic csr_valid, csr_ready;
   logic [sovb_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_data;

   int mismatches, pending, applied_count;
   int items_sent, settings_used, idle_pct;
   logic [31:0] anchor_cur [3];

   spring_offset_velocity_blend_core u_dut (.*);

   sovb_checker u_checker (.*);

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Present one item and hold it until accepted, then maybe idle.
   task automatic send_item(input logic [31:0] px, py, pz, vx, vy, vz, dt);
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_vel_x <= vx;
      req_vel_y <= vy;
      req_vel_z <= vz;
      req_time_step <= dt;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   // Stop sending and wait until every outstanding item has come back.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   // Write all registers back to back, plus one write to an unmapped index.
   task automatic write_settings(input logic [31:0] ax, ay, az, rd, sc, armed);
      logic [sovb_pkg::CSR_INDEX_W-1:0] idx [7];
      logic [31:0] val [7];
      idx = '{sovb_pkg::REG_ANCHOR_X, sovb_pkg::REG_ANCHOR_Y, sovb_pkg::REG_ANCHOR_Z,
              sovb_pkg::REG_REST_DISTANCE, sovb_pkg::REG_TIME_SCALE,
              sovb_pkg::REG_TARGET_SET, REG_UNMAPPED};
      val = '{ax, ay, az, rd, sc, armed, $urandom};
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      anchor_cur = '{ax, ay, az};
      settings_used++;
   endtask

   function automatic logic [31:0] spread_word();
      longint v;
      v = longint'($urandom) >> $urandom_range(0, 31);
      return $urandom_range(0, 1) ? 32'(-v) : 32'(v);
   endfunction

   // Random item, mostly near the anchor so the spring has work to do.
   task automatic send_random();
      logic [31:0] pos [3], vel [3], dt;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         if (mode <= 5)      pos[i] = anchor_cur[i] + spread_word();
         else if (mode <= 8) pos[i] = $urandom;
         else                pos[i] = anchor_cur[i] + 32'($signed($urandom_range(0, 2)) - 1);
         vel[i] = ($urandom_range(0, 3) == 0) ? $urandom : spread_word();
      end
      case ($urandom_range(0, 3))
         0:       dt = 32'h0;
         1:       dt = $urandom;
         default: dt = $urandom_range(0, 32'h0002_0000);
      endcase
      send_item(pos[0], pos[1], pos[2], vel[0], vel[1], vel[2], dt);
   endtask

   initial begin
      logic [31:0] sc, ax, ay, az, armed;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_vel_z = '0;
      req_time_step = '0;
      items_sent = 0;
      settings_used = 0;
      idle_pct = 0;
      anchor_cur = '{default: '0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Target not set after reset: velocity passes through.
      send_item(32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0000_1000);
      send_item('1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 0, '1);
      drain();

      // Unit time scale, unit rest distance, anchor at the origin.
      write_settings(0, 0, 0, 32'h0001_0000, SCALE_ONE, 1);
      send_item(32'h0005_0000, 0, 0, 0, 0, 0, 32'h0000_0444);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
      send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
      send_item(0, 0, 0, 32'h0001_0000, 0, 0, SCALE_ONE);      // zero distance
      send_item(1, 0, 0, 32'h0001_0000, 0, 0, SCALE_ONE);      // one LSB away
      send_item(2, 0, 0, 32'h0001_0000, 0, 0, SCALE_ONE);      // just applies
      send_item(0, 32'h0003_0000, 32'hFFFC_0000,
                32'h0001_0000, 32'hFFFE_0000, 32'h0003_0000, 0);
      send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
                32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0000_8000);
      drain();

      // Anchor at the low corner, largest rest distance, smallest time scale.
      write_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, 1, 32'hFFFF_FFFF);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 1);
      send_item(32'h8000_0001, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1);
      drain();

      // Time scale zero, at the limit, and just under it.
      write_settings(0, 0, 0, 32'h0002_0000, 0, 1);
      send_item(32'h0004_0000, 0, 0, 32'h0001_0000, 0, 0, SCALE_ONE);
      drain();
      write_settings(0, 0, 0, 32'h0002_0000, SCALE_LIMIT, 1);
      send_item(32'h0004_0000, 0, 0, 32'h0001_0000, 0, 0, SCALE_ONE);
      drain();
      write_settings(0, 0, 0, 32'h0002_0000, SCALE_LIMIT - 1, 1);
      send_item(32'h0004_0000, 0, 0, 32'h0001_0000, 0, 0, '1);
      send_item(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, SCALE_LIMIT);
      drain();

      // Random items over several spring settings.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: sc = SCALE_ONE;
            2: sc = 1;
            3: sc = SCALE_LIMIT - 1;
            default: sc = $urandom_range(1, SCALE_LIMIT - 1);
         endcase
         ax = (ph == 2) ? 32'h8000_0000 : (ph == 3) ? 32'h7FFF_FFFF : spread_word();
         ay = (ph == 2) ? 32'h8000_0000 : (ph == 3) ? 32'h7FFF_FFFF : spread_word();
         az = (ph == 2) ? 32'h8000_0000 : (ph == 3) ? 32'h7FFF_FFFF : spread_word();
         armed = {31'($urandom_range(0, 32'h7FFF_FFFF)), (ph != 4)};
         write_settings(ax, ay, az, $urandom >> $urandom_range(0, 16), sc, armed);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph < 2)      idle_pct = 35;
            else if (ph < 4) idle_pct = 56;
            else             idle_pct = 0;
            send_random();
         end
         idle_pct = 0;
         drain();
      end

      $display("Sent %0d items under %0d register settings; %0d took the spring update.",
               items_sent, settings_used, applied_count);
      $display("Covered pass-through cases, extreme anchors, time scales and saturation.");
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/sovb_pkg.sv
rtl/core/sovb_sqrt.sv
rtl/core/sovb_div.sv
rtl/core/spring_offset_velocity_blend_core.sv
verif/sovb_checker.sv
verif/tb_spring_offset_velocity_blend_core.sv
